>>> design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants for the UTF-8 stream decoder
// Status codes, the result record passed between stages, and the lead-byte
// masks of the legacy 1-to-6-byte encoding.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 31;
	localparam int REM_W  = 3;

	// Payload bits carried by one continuation byte
	localparam int CONT_BITS = 6;

	localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_DATA = 8'h3F;

	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;
	localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
	localparam logic [BYTE_W-1:0] LEAD5_TAG  = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD5_DATA = 8'h03;
	localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFE;
	localparam logic [BYTE_W-1:0] LEAD6_TAG  = 8'hFC;
	localparam logic [BYTE_W-1:0] LEAD6_DATA = 8'h01;

	// Deepest sequence: a six-byte lead leaves five continuations open
	localparam logic [REM_W-1:0] REM_MAX = 3'd5;

	typedef enum logic [1:0] {
		ST_CHAR       = 2'd0,
		ST_ACCEPTED   = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_BAD        = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [CP_W-1:0]   code_point;
	} result_t;

endpackage

>>> design/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: legacy six-byte UTF-8 byte stream decoder
// One byte in, one result out: character complete, byte accepted,
// sequence incomplete or bad byte, with the code point of each character.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | request   | in_valid / in_stall  | in_byte[7:0]
//  out     | result    | out_valid / out_stall| status[1:0], code_point[30:0]
//
//  One byte per cycle sustained while out_stall stays low; a taken request
//  loads the input register, its result is then loaded into the result
//  register when that has room, and it is shown there until taken.
//  The decode step between the two registers is a single mask-and-shift
//  update of the open-sequence count and the 31-bit accumulator.
//  arst_n clears both valid flags and the open-sequence count; the
//  accumulator is only read after a lead byte has written it.
//  in_stall rises only while the input register holds a byte and the
//  result register is full and stalled; out_stall backs up one stage.
//
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [u8d_pkg::CP_W-1:0]    code_point
);
	import u8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_ready;
	logic              fire;
	result_t           dec_res;
	result_t           out_res;

	// advance the held byte into the result register when there is room
	assign fire     = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte while stalled, otherwise capture each new request
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	u8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.res     (dec_res)
	);

	u8d_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (dec_res),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (out_res)
	);

	assign status     = out_res.status;
	assign code_point = out_res.code_point;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("utf8_stream_decoder: stall without a blocked byte");

	a_fire_flows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("utf8_stream_decoder: decoded byte produced no result");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("utf8_stream_decoder: accepted byte not held");

endmodule

>>> design/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode: per-byte decode step and sequence state
// Holds the open-sequence count and the code point accumulator, and turns
// one byte into one result record.
// ----------------------------------------------------------------------------
module u8d_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [u8d_pkg::BYTE_W-1:0]  byte_in,
	output u8d_pkg::result_t            res
);
	import u8d_pkg::*;

	logic [REM_W-1:0] rem_q, rem_d;
	logic [CP_W-1:0]  acc_q, acc_d;

	always_comb begin
		res.status     = ST_ACCEPTED;
		res.code_point = '0;
		rem_d          = rem_q;
		acc_d          = acc_q;
		if (rem_q != '0) begin
			if ((byte_in & CONT_MASK) == CONT_TAG) begin
				rem_d = rem_q - REM_W'(1);
				acc_d = {acc_q[CP_W-CONT_BITS-1:0], byte_in[CONT_BITS-1:0]};
				if (rem_q == REM_W'(1)) begin
					res.status     = ST_CHAR;
					res.code_point = acc_d;
				end
			end else begin
				// drop the interrupted sequence; the byte is consumed
				rem_d      = '0;
				res.status = ST_INCOMPLETE;
			end
		end else if (!byte_in[BYTE_W-1]) begin
			res.status     = ST_CHAR;
			res.code_point = CP_W'(byte_in);
		end else if ((byte_in & LEAD2_MASK) == LEAD2_TAG) begin
			rem_d = REM_W'(1);
			acc_d = CP_W'(byte_in & LEAD2_DATA);
		end else if ((byte_in & LEAD3_MASK) == LEAD3_TAG) begin
			rem_d = REM_W'(2);
			acc_d = CP_W'(byte_in & LEAD3_DATA);
		end else if ((byte_in & LEAD4_MASK) == LEAD4_TAG) begin
			rem_d = REM_W'(3);
			acc_d = CP_W'(byte_in & LEAD4_DATA);
		end else if ((byte_in & LEAD5_MASK) == LEAD5_TAG) begin
			rem_d = REM_W'(4);
			acc_d = CP_W'(byte_in & LEAD5_DATA);
		end else if ((byte_in & LEAD6_MASK) == LEAD6_TAG) begin
			rem_d = REM_MAX;
			acc_d = CP_W'(byte_in & LEAD6_DATA);
		end else begin
			res.status = ST_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (fire) begin
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			acc_q <= acc_d;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_MAX)
		else $error("u8d_decode: open count beyond five");

	a_last_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rem_q != '0 && res.status == ST_CHAR) |-> rem_q == REM_W'(1))
		else $error("u8d_decode: character completed early");

	a_lead_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rem_q == '0 && res.status == ST_ACCEPTED) |=> rem_q != '0)
		else $error("u8d_decode: lead byte opened no sequence");

	a_break_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.status == ST_INCOMPLETE) |=> rem_q == '0)
		else $error("u8d_decode: interrupted sequence left open");

endmodule

>>> design/u8d_outreg.sv
// ----------------------------------------------------------------------------
// u8d_outreg: result register
// Holds one result record until the consumer takes it.
// ----------------------------------------------------------------------------
module u8d_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  u8d_pkg::result_t  res_in,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output u8d_pkg::result_t  res_out
);
	import u8d_pkg::*;

	logic    valid_q;
	result_t res_q;

	// take a new record when empty or when the held one leaves this cycle
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res_in;
		end
	end

	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.status != ST_CHAR) |-> res_q.code_point == '0)
		else $error("u8d_outreg: code point set on a non-character result");

	a_no_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> valid_q)
		else $error("u8d_outreg: held result lost");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && load) |=> valid_q)
		else $error("u8d_outreg: loaded result not shown");

endmodule

>>> dv/utf8_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_result_checker: scoreboard for the UTF-8 stream decoder
// Watches both channels, decodes each accepted request on its own model of
// the open-sequence count and accumulator, and compares every result.
// ----------------------------------------------------------------------------
module utf8_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  status,
	input  logic [u8d_pkg::CP_W-1:0]    code_point,
	output int                          fail_count,
	output int                          pending,
	output int                          checked,
	output int                          chars,
	output int                          incompletes,
	output int                          bad_bytes
);

	import u8d_pkg::*;

	logic [REM_W-1:0] seq_left;
	logic [CP_W-1:0]  seq_acc;
	result_t          predicted_results[$];

	// Decode one byte and advance the sequence state.
	function automatic result_t decode_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		r.status     = ST_ACCEPTED;
		r.code_point = '0;
		if (seq_left != '0) begin
			if ((b & CONT_MASK) == CONT_TAG) begin
				seq_left = seq_left - REM_W'(1);
				seq_acc  = {seq_acc[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
				if (seq_left == '0) begin
					r.status     = ST_CHAR;
					r.code_point = seq_acc;
				end
			end else begin
				seq_left = '0;
				r.status = ST_INCOMPLETE;
			end
		end else if (!b[BYTE_W-1]) begin
			r.status     = ST_CHAR;
			r.code_point = {{(CP_W-BYTE_W+1){1'b0}}, b[BYTE_W-2:0]};
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			seq_left = 3'd1;
			seq_acc  = CP_W'(b & LEAD2_DATA);
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			seq_left = 3'd2;
			seq_acc  = CP_W'(b & LEAD3_DATA);
		end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
			seq_left = 3'd3;
			seq_acc  = CP_W'(b & LEAD4_DATA);
		end else if ((b & LEAD5_MASK) == LEAD5_TAG) begin
			seq_left = 3'd4;
			seq_acc  = CP_W'(b & LEAD5_DATA);
		end else if ((b & LEAD6_MASK) == LEAD6_TAG) begin
			seq_left = REM_MAX;
			seq_acc  = CP_W'(b & LEAD6_DATA);
		end else begin
			r.status = ST_BAD;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		result_t want;
		if (!arst_n) begin
			seq_left = '0;
			seq_acc  = '0;
			predicted_results.delete();
			pending = 0;
		end else begin
			// Compare first: a request taken at this edge cannot be the result now.
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					fail_count++;
					$error("result with nothing expected: status %0d, code_point 0x%08h",
						status, code_point);
				end else begin
					want = predicted_results.pop_front();
					checked++;
					case (want.status)
						ST_CHAR:       chars++;
						ST_INCOMPLETE: incompletes++;
						ST_BAD:        bad_bytes++;
						default:       ;
					endcase
					if (status !== want.status) begin
						fail_count++;
						$error("status: expected %0d, actual %0d", want.status, status);
					end
					if (code_point !== want.code_point) begin
						fail_count++;
						$error("code_point: expected 0x%08h, actual 0x%08h",
							want.code_point, code_point);
					end
				end
			end
			if (in_valid && !in_stall)
				predicted_results.push_back(decode_byte(in_byte));
			pending = predicted_results.size();
		end
	end

endmodule

>>> dv/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder: stimulus and verdict for the UTF-8 stream decoder
// Sends a short directed byte list, then random well-formed, broken and
// stray sequences under random idling on both channels; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

	import u8d_pkg::*;

	localparam int N_ITEMS       = 1150;
	// Nothing accepted for this many cycles ends the run. The slowest correct
	// stretch is the long receiver hold below; allow several times that.
	localparam int STALL_LIMIT   = 2000;
	localparam int PRESSURE_AT   = 300;
	localparam int PRESSURE_HOLD = 400;
	// Two register stages; leave some margin for stray results.
	localparam int DRAIN_CYCLES  = 20;

	// Directed bytes: ASCII extremes, stray continuation and 0xFF, each lead
	// length from two to six (overlong zero of two and four, largest of three
	// and six, smallest of five bytes), and a sequence broken by an ASCII byte.
	localparam logic [BYTE_W-1:0] DIRECTED [26] = '{
		8'h00, 8'h7F, 8'h80, 8'hFF,
		8'hC0, 8'h80,
		8'hEF, 8'hBF, 8'hBF,
		8'hF0, 8'h80, 8'h80, 8'h80,
		8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
		8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
		8'hE2, 8'h41
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [BYTE_W-1:0]   in_byte;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [CP_W-1:0]     code_point;

	int fail_count;
	int pending;
	int checked;
	int chars;
	int incompletes;
	int bad_bytes;

	// Request and result counters kept by the two driving processes
	int sent;
	int taken;
	// When set, the side runs with no idle cycles until the next redraw
	bit tx_calm;
	bit rx_calm;

	utf8_stream_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.code_point (code_point)
	);

	utf8_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.code_point  (code_point),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.chars       (chars),
		.incompletes (incompletes),
		.bad_bytes   (bad_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hold reset low from the start, then release it once for the whole run.
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Lead byte of a sequence of len bytes with random payload bits.
	function automatic logic [BYTE_W-1:0] lead_byte(input int len);
		logic [BYTE_W-1:0] r;
		r = BYTE_W'($urandom);
		case (len)
			1:       return {1'b0, r[BYTE_W-2:0]};
			2:       return LEAD2_TAG | (r & LEAD2_DATA);
			3:       return LEAD3_TAG | (r & LEAD3_DATA);
			4:       return LEAD4_TAG | (r & LEAD4_DATA);
			5:       return LEAD5_TAG | (r & LEAD5_DATA);
			default: return LEAD6_TAG | (r & LEAD6_DATA);
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] cont_byte();
		return CONT_TAG | (BYTE_W'($urandom) & CONT_DATA);
	endfunction

	// Offer one request after a random gap and hold it until taken. Valid
	// stays high across back-to-back requests; only the byte changes.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent++;
		if (sent % 50 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	// Receiver: draw a stall before every result, then take it. Once, hold
	// off for a long stretch so the block fills and stalls its input.
	initial begin : receiver
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 19);
			if (taken == PRESSURE_AT)
				hold = PRESSURE_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 50 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$error("no handshake for %0d cycles", STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Stimulus and verdict
	initial begin : stimulus
		int kind;
		int len;
		logic [BYTE_W-1:0] b;
		in_valid <= 1'b0;
		in_byte  <= '0;
		@(posedge arst_n);
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		// Mostly well-formed characters of every length, with some broken
		// sequences, stray continuations and plain noise mixed in.
		while (sent < N_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				len = $urandom_range(1, 6);
				send_byte(lead_byte(len));
				repeat (len - 1) send_byte(cont_byte());
			end else if (kind == 7) begin
				// Open a sequence, cut it short, and interrupt it with a
				// byte whose top bits are not a continuation tag.
				len = $urandom_range(2, 6);
				send_byte(lead_byte(len));
				repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
				b = BYTE_W'($urandom);
				if ((b & CONT_MASK) == CONT_TAG)
					b = b ^ 8'h40;
				send_byte(b);
			end else if (kind == 8) begin
				if ($urandom_range(0, 3) == 0)
					send_byte($urandom_range(0, 1) ? 8'hFE : 8'hFF);
				else
					send_byte(cont_byte());
			end else begin
				send_byte(BYTE_W'($urandom));
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every expected result, then watch for strays.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d bytes sent, %0d results checked", sent, checked);
		$display("summary: %0d characters, %0d broken sequences, %0d bad bytes, hold of %0d cycles",
			chars, incompletes, bad_bytes, PRESSURE_HOLD);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
